// File: rtl/core/priority_thread_scheduler_macros.svh
// Assertion macros shared by the scheduler checker.
// No dependencies; included by the checker file.
`ifndef PRIORITY_THREAD_SCHEDULER_MACROS_SVH
`define PRIORITY_THREAD_SCHEDULER_MACROS_SVH

// Clocked assertion, off while reset is held.
`define PSCHED_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that also holds across reset.
`define PSCHED_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// File: rtl/core/psched_pkg.sv
// Shared types and constants for the priority thread scheduler.
// No dependencies; used by psched_cell and the top level.
package psched_pkg;

    localparam int DEF_NUM_THREADS = 8;
    localparam int DEF_NUM_SEMS    = 8;

    localparam int PRIO_W    = 8;
    localparam int PRIO_REGS = 8;
    localparam int CFG_IDX_W = 4;
    localparam int SLEEP_W   = 32;
    localparam int SEM_W     = 16;
    localparam int SID_W     = 3;
    localparam int REQ_W     = 3;
    localparam int RUN_W     = 3;
    localparam int THR_ID_W  = 5;   // covers up to 32 threads
    localparam int IN_W      = 56;  // 51 payload bits padded to bytes
    localparam int OUT_W     = 24;  // 22 payload bits padded to bytes

    localparam logic [PRIO_W-1:0]       PRIO_NONE = 8'd255;
    localparam logic signed [SEM_W-1:0] SEM_MAX   = 16'sh7FFF;
    localparam logic signed [SEM_W-1:0] SEM_MIN   = 16'sh8000;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_SCHED  = 3'd1,
        REQ_SLEEP  = 3'd2,
        REQ_WAIT   = 3'd3,
        REQ_SIGNAL = 3'd4,
        REQ_INIT   = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_TICK,
        CELL_SLEEP,
        CELL_BLOCK,
        CELL_WAKE
    } t_cell_op;

    // Broadcast update to all thread cells.
    typedef struct packed {
        t_cell_op              op;
        logic [THR_ID_W-1:0]   tgt;
        logic [SLEEP_W-1:0]    sleep_val;
        logic [SID_W-1:0]      sid;
    } t_cell_cmd;

    // Scan context held steady while the chain settles.
    typedef struct packed {
        logic                  wake_mode;  // 1: find blocked thread for signal
        logic [THR_ID_W-1:0]   cur;
        logic [SID_W-1:0]      sid;
    } t_scan_ctl;

    // Best candidate so far, passed cell to cell.
    typedef struct packed {
        logic                  found;
        logic [PRIO_W-1:0]     prio;
        logic [THR_ID_W-1:0]   hops;
        logic [THR_ID_W-1:0]   idx;
    } t_scan;

endpackage

// File: rtl/core/psched_cell.sv
// One thread cell: sleep counter, block mark, priority and one scan stage.
// Depends on psched_pkg.
module psched_cell #(
    parameter int NUM_THREADS = psched_pkg::DEF_NUM_THREADS,
    parameter int IDX         = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psched_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psched_pkg::PRIO_W-1:0]     i_cfg_wdata,
    input  psched_pkg::t_cell_cmd             i_cmd,
    input  psched_pkg::t_scan_ctl             i_ctl,
    input  psched_pkg::t_scan                 i_scan,
    output psched_pkg::t_scan                 o_scan
);
    import psched_pkg::*;

    localparam int DW = THR_ID_W + 1;
    localparam logic [THR_ID_W-1:0] MY_ID = THR_ID_W'(IDX);

    logic [SLEEP_W-1:0]  r_sleep;
    logic                r_blk;
    logic [SID_W-1:0]    r_blk_sid;
    t_scan               r_scan;
    t_scan               n_scan;
    logic [PRIO_W-1:0]   w_prio;
    logic [DW-1:0]       w_tmp;
    logic [THR_ID_W-1:0] w_dist;
    logic [PRIO_W-1:0]   w_key;
    logic                w_elig;
    logic                w_better;
    logic                w_hit;

    // Only the first PRIO_REGS threads have a priority register; the rest run at 0.
    generate
        if (IDX < PRIO_REGS) begin : g_prio
            logic [PRIO_W-1:0] r_prio;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_prio <= '0;
                end else if (i_cfg_we && i_cfg_idx == CFG_IDX_W'(IDX)) begin
                    r_prio <= i_cfg_wdata;
                end
            end
            assign w_prio = r_prio;
        end else begin : g_noprio
            assign w_prio = '0;
        end
    endgenerate

    // Ring distance from the thread after the running one.
    always_comb begin
        w_tmp  = DW'(IDX + NUM_THREADS - 1) - {1'b0, i_ctl.cur};
        w_dist = (w_tmp >= DW'(NUM_THREADS)) ? THR_ID_W'(w_tmp - DW'(NUM_THREADS))
                                              : THR_ID_W'(w_tmp);
        w_elig = i_ctl.wake_mode ? (r_blk && r_blk_sid == i_ctl.sid)
                                 : (w_prio != PRIO_NONE && !r_blk && r_sleep == '0);
        w_key  = i_ctl.wake_mode ? '0 : w_prio;
        w_better = w_elig && (!i_scan.found || w_key < i_scan.prio
                   || (w_key == i_scan.prio && w_dist < i_scan.hops));
        n_scan = i_scan;
        if (w_better) begin
            n_scan.found = 1'b1;
            n_scan.prio  = w_key;
            n_scan.hops  = w_dist;
            n_scan.idx   = MY_ID;
        end
        w_hit = (i_cmd.tgt == MY_ID);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep   <= '0;
            r_blk     <= 1'b0;
            r_blk_sid <= '0;
            r_scan    <= '0;
        end else begin
            r_scan <= n_scan;
            unique case (i_cmd.op)
                CELL_NOP: ;
                CELL_TICK: begin
                    if (r_sleep != '0) r_sleep <= r_sleep - SLEEP_W'(1);
                end
                CELL_SLEEP: begin
                    if (w_hit) r_sleep <= i_cmd.sleep_val;
                end
                CELL_BLOCK: begin
                    if (w_hit) begin
                        r_blk     <= 1'b1;
                        r_blk_sid <= i_cmd.sid;
                    end
                end
                CELL_WAKE: begin
                    if (w_hit) r_blk <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_scan = r_scan;

endmodule

// File: rtl/core/priority_thread_scheduler.sv
// Schedule and signal: after the request is accepted, the scan ripples down the cell
// chain in the scan state, and the result is registered at commit. Other requests go
// straight to commit. Commit waits while the result register holds an undrained result.
// One request in flight: the next request is taken only once the result is committed.
// Synchronous active-low reset clears all thread, semaphore and priority state.
// Depends on psched_pkg and psched_cell.
module priority_thread_scheduler #(
    parameter int NUM_THREADS    = psched_pkg::DEF_NUM_THREADS,
    parameter int NUM_SEMAPHORES = psched_pkg::DEF_NUM_SEMS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: priority registers 0..7
    input  logic                              i_cfg_we,
    input  logic [psched_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psched_pkg::PRIO_W-1:0]     i_cfg_wdata,
    // request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: sleep_ms[31:0], sem_id[34:32], init_value[50:35], zero pad
    input  logic [psched_pkg::IN_W-1:0]       s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [psched_pkg::REQ_W-1:0]      s_axis_tuser,
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: running_thread[2:0], none_ready[3], must_suspend[4],
    //        sem_count[20:5], signal_miss[21], zero pad
    output logic [psched_pkg::OUT_W-1:0]      m_axis_tdata
);
    import psched_pkg::*;

    localparam int TW     = $clog2(NUM_THREADS);
    localparam int SEM_D  = (NUM_SEMAPHORES < 8) ? NUM_SEMAPHORES : 8;  // 3-bit sem_id reaches 7
    localparam int SEM_AW = (SEM_D > 1) ? $clog2(SEM_D) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } t_state;

    t_state                   r_state, n_state;
    logic [TW-1:0]            r_cnt, n_cnt;
    logic [TW-1:0]            r_cur, n_cur;
    t_req                     r_req;
    logic [SLEEP_W-1:0]       r_sleep_ms;
    logic [SID_W-1:0]         r_sid;
    logic signed [SEM_W-1:0]  r_ival;
    logic signed [SEM_W-1:0]  r_sem [SEM_D];
    logic                     r_out_valid, n_out_valid;
    logic [OUT_W-1:0]         r_out_data, n_out_data;

    logic                     w_accept;
    logic                     w_go;
    logic                     w_sem_ok;
    logic [SEM_AW-1:0]        w_sem_idx;
    logic signed [SEM_W-1:0]  w_sem_rd;
    logic signed [SEM_W-1:0]  w_new_cnt;
    logic                     w_sem_we;
    logic signed [SEM_W-1:0]  w_rep_cnt;
    logic                     w_none, w_susp, w_miss;
    t_cell_cmd                w_cmd;
    t_scan_ctl                w_ctl;
    t_scan                    w_scan [NUM_THREADS+1];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Commit only when the output register is free or being drained.
    assign w_go = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);

    // Semaphore table read; ids past the table report nothing.
    assign w_sem_ok  = (int'(r_sid) < SEM_D);
    assign w_sem_idx = r_sid[SEM_AW-1:0];
    assign w_sem_rd  = w_sem_ok ? r_sem[w_sem_idx] : '0;

    // Scan context stays fixed from the first scan cycle through commit.
    always_comb begin
        w_ctl.wake_mode = (r_req == REQ_SIGNAL);
        w_ctl.cur       = THR_ID_W'(r_cur);
        w_ctl.sid       = r_sid;
    end

    // Cell chain: each stage keeps the better of its own thread and its neighbor's pick.
    assign w_scan[0] = '0;
    generate
        for (genvar g = 0; g < NUM_THREADS; g++) begin : g_cell
            psched_cell #(
                .NUM_THREADS (NUM_THREADS),
                .IDX         (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cfg_we    (i_cfg_we),
                .i_cfg_idx   (i_cfg_idx),
                .i_cfg_wdata (i_cfg_wdata),
                .i_cmd       (w_cmd),
                .i_ctl       (w_ctl),
                .i_scan      (w_scan[g]),
                .o_scan      (w_scan[g+1])
            );
        end
    endgenerate

    // Request decode at commit.
    always_comb begin
        w_cmd.op        = CELL_NOP;
        w_cmd.tgt       = THR_ID_W'(r_cur);
        w_cmd.sleep_val = r_sleep_ms;
        w_cmd.sid       = r_sid;
        w_new_cnt       = w_sem_rd;
        w_sem_we        = 1'b0;
        w_rep_cnt       = '0;
        w_none          = 1'b0;
        w_susp          = 1'b0;
        w_miss          = 1'b0;
        n_cur           = r_cur;
        unique case (r_req)
            REQ_TICK: begin
                w_cmd.op = CELL_TICK;
            end
            REQ_SCHED: begin
                if (w_scan[NUM_THREADS].found) begin
                    n_cur = TW'(w_scan[NUM_THREADS].idx);
                end else begin
                    w_none = 1'b1;
                end
            end
            REQ_SLEEP: begin
                w_cmd.op = CELL_SLEEP;
                w_susp   = 1'b1;
            end
            REQ_WAIT: begin
                if (w_sem_ok) begin
                    // saturate at the most negative count; thread still blocks
                    w_new_cnt = (w_sem_rd == SEM_MIN) ? w_sem_rd : w_sem_rd - SEM_W'(1);
                    w_sem_we  = 1'b1;
                    w_rep_cnt = w_new_cnt;
                    if (w_new_cnt[SEM_W-1]) begin
                        w_cmd.op = CELL_BLOCK;
                        w_susp   = 1'b1;
                    end
                end
            end
            REQ_SIGNAL: begin
                if (w_sem_ok) begin
                    w_new_cnt = (w_sem_rd == SEM_MAX) ? w_sem_rd : w_sem_rd + SEM_W'(1);
                    w_sem_we  = 1'b1;
                    w_rep_cnt = w_new_cnt;
                    if (w_new_cnt[SEM_W-1] || w_new_cnt == '0) begin
                        if (w_scan[NUM_THREADS].found) begin
                            w_cmd.op  = CELL_WAKE;
                            w_cmd.tgt = w_scan[NUM_THREADS].idx;
                        end else begin
                            w_miss = 1'b1;
                        end
                    end
                end
            end
            REQ_INIT: begin
                if (w_sem_ok) begin
                    w_new_cnt = r_ival;
                    w_sem_we  = 1'b1;
                    w_rep_cnt = r_ival;
                end
            end
            default: ;  // unused codes leave everything alone
        endcase
        if (!w_go) begin
            w_cmd.op = CELL_NOP;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    if (t_req'(s_axis_tuser) == REQ_SCHED
                        || t_req'(s_axis_tuser) == REQ_SIGNAL) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + TW'(1);
                if (r_cnt == TW'(NUM_THREADS - 1)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_go) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, w_miss, w_rep_cnt, w_susp, w_none, RUN_W'(n_cur)};
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SEM_D; k++) begin
                r_sem[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (w_go) begin
                r_cur <= n_cur;
                if (w_sem_we) r_sem[w_sem_idx] <= w_new_cnt;
            end
        end
        // request payload and result data need no reset
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_req      <= t_req'(s_axis_tuser);
            r_sleep_ms <= s_axis_tdata[31:0];
            r_sid      <= s_axis_tdata[34:32];
            r_ival     <= s_axis_tdata[50:35];
        end
    end

endmodule

// File: rtl/core/psched_checker.sv
// Port-level checks for priority_thread_scheduler, bound to the top level.
// Depends on psched_pkg and priority_thread_scheduler_macros.svh.
`include "priority_thread_scheduler_macros.svh"

module psched_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [psched_pkg::OUT_W-1:0]      m_axis_tdata
);
    import psched_pkg::*;

    // no result survives reset
    `PSCHED_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // one request at a time: after a request is taken the input side closes
    `PSCHED_ASSERT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // stalled result holds
    `PSCHED_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // none_ready comes only from schedule, which never suspends or misses
    `PSCHED_ASSERT(a_flag_excl, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[4] && !m_axis_tdata[21])

endmodule

bind priority_thread_scheduler psched_checker u_psched_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb.sv
// Testbench for priority_thread_scheduler: random and directed scheduler requests
// checked against a cycle-free behavioral mirror held in a scoreboard class.
// Depends on psched_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb;
    import psched_pkg::*;

    // Mirror of the scheduler state; predicts one result per accepted request.
    class sched_tracker;
        typedef struct {
            bit [2:0]         run;
            bit               none;
            bit               susp;
            bit signed [15:0] cnt;
            bit               miss;
        } t_sched_result;

        bit [7:0]         prio[8];
        bit [31:0]        sleep_left[8];
        bit               blocked[8];
        bit [2:0]         blocked_sem[8];
        bit signed [15:0] sem_cnt[8];
        bit [2:0]         running;
        t_sched_result    due_results[$];
        int               errors;

        function void set_prio(input bit [3:0] idx, input bit [7:0] val);
            if (idx < 8) prio[idx[2:0]] = val;   // higher indexes are ignored by the block
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_request(input logic [2:0] req, input logic [IN_W-1:0] data);
            bit [31:0]     ms;
            bit [2:0]      sid;
            bit [2:0]      t;
            bit [2:0]      best;
            int            best_prio;
            bit            found;
            bit            woke;
            t_sched_result r;
            ms  = data[31:0];
            sid = data[34:32];
            r   = '{default: 0};
            case (req)
                REQ_TICK: begin
                    for (int i = 0; i < 8; i++)
                        if (sleep_left[i] != 0) sleep_left[i]--;
                end
                REQ_SCHED: begin
                    // ring scan from the thread after the running one, running one last
                    best_prio = 255;
                    best      = running;
                    found     = 0;
                    t         = running;
                    for (int i = 0; i < 8; i++) begin
                        t = t + 3'd1;
                        if (int'(prio[t]) < best_prio && !blocked[t] && sleep_left[t] == 0)
                        begin
                            best      = t;
                            best_prio = int'(prio[t]);
                            found     = 1;
                        end
                    end
                    if (found) running = best;
                    else r.none = 1;
                end
                REQ_SLEEP: begin
                    sleep_left[running] = ms;
                    r.susp = 1;
                end
                REQ_WAIT: begin
                    if (sem_cnt[sid] != SEM_MIN) sem_cnt[sid]--;
                    if (sem_cnt[sid] < 0) begin
                        blocked[running]     = 1;
                        blocked_sem[running] = sid;
                        r.susp = 1;
                    end
                    r.cnt = sem_cnt[sid];
                end
                REQ_SIGNAL: begin
                    if (sem_cnt[sid] != SEM_MAX) sem_cnt[sid]++;
                    if (sem_cnt[sid] <= 0) begin
                        woke = 0;
                        t    = running;
                        for (int i = 0; i < 8 && !woke; i++) begin
                            t = t + 3'd1;
                            if (blocked[t] && blocked_sem[t] == sid) begin
                                blocked[t] = 0;
                                woke = 1;
                            end
                        end
                        if (!woke) r.miss = 1;
                    end
                    r.cnt = sem_cnt[sid];
                end
                REQ_INIT: begin
                    sem_cnt[sid] = data[50:35];
                    r.cnt = sem_cnt[sid];
                end
                default: ;  // unused codes change nothing
            endcase
            r.run = running;
            due_results.push_back(r);
        endfunction

        function void cmp_field(input string name, input int exp_v, input int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input logic [OUT_W-1:0] d);
            t_sched_result e;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, d);
                return;
            end
            e = due_results.pop_front();
            cmp_field("running_thread", int'(e.run), int'(d[2:0]));
            cmp_field("none_ready", int'(e.none), int'(d[3]));
            cmp_field("must_suspend", int'(e.susp), int'(d[4]));
            cmp_field("sem_count", int'(e.cnt), int'($signed(d[20:5])));
            cmp_field("signal_miss", int'(e.miss), int'(d[21]));
        endfunction
    endclass

    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake on either side
    localparam int HOLD_LEN   = 400;    // long receiver hold-off

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [PRIO_W-1:0]    i_cfg_wdata = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_tdata     = '0;
    logic [REQ_W-1:0]     s_tuser     = '0;
    logic                 m_axis_tvalid;
    logic                 m_tready    = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    sched_tracker sb = new();
    bit calm;       // set: no gaps on either side
    bit hold_off;   // main asks the receiver for one long stall

    priority_thread_scheduler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int w;
        if (calm) return 0;
        w = $urandom_range(0, 99);
        if (w < 50) return 0;
        if (w < 85) return $urandom_range(1, 3);
        if (w < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // tdata: sleep_ms[31:0], sem_id[34:32], init_value[50:35], zero pad
    function automatic logic [IN_W-1:0] pack_req(input bit [31:0] ms, input bit [2:0] sid,
                                                 input bit [15:0] iv);
        return {5'b0, iv, sid, ms};
    endfunction

    // Offer one request and return at the edge where it is taken.
    task automatic send_req(input logic [2:0] req, input logic [IN_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sender pause: wait until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input bit [3:0] idx, input bit [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_prio(idx, val);
    endtask

    // All eight priorities plus one write to an unused index.
    task automatic load_prios(input bit [7:0] vals[8]);
        for (int i = 0; i < 8; i++) write_reg(4'(i), vals[i]);
        write_reg(4'($urandom_range(8, 15)), 8'($urandom_range(0, 255)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        logic [2:0] req;
        bit [31:0]  ms;
        bit [2:0]   sid;
        bit [15:0]  iv;
        int         w;
        // fields a request does not use carry random junk
        ms  = $urandom;
        sid = 3'($urandom_range(0, 7));
        iv  = 16'($urandom_range(0, 65535));
        w   = $urandom_range(0, 99);
        if (w < 25) req = REQ_TICK;
        else if (w < 50) req = REQ_SCHED;
        else if (w < 60) req = REQ_SLEEP;
        else if (w < 75) req = REQ_WAIT;
        else if (w < 89) req = REQ_SIGNAL;
        else if (w < 97) req = REQ_INIT;
        else req = 3'($urandom_range(6, 7));
        if (req == REQ_SLEEP) begin
            // keep sleeps short so threads come back; rare huge ones
            w = $urandom_range(0, 99);
            if (w < 70) ms = $urandom_range(0, 6);
            else if (w < 98) ms = $urandom_range(7, 40);
        end
        if (req == REQ_WAIT || req == REQ_SIGNAL || req == REQ_INIT)
            if ($urandom_range(0, 99) < 75) sid = 3'($urandom_range(0, 2));
        if (req == REQ_INIT) begin
            w = $urandom_range(0, 99);
            if (w < 60) iv = 16'($urandom_range(0, 6) - 3);
            else if (w < 70) iv = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        end
        send_req(req, pack_req(ms, sid, iv));
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) random_request();
    endtask

    // Directed requests from reset state (all priorities 0, thread 0 running).
    task automatic directed_requests();
        send_req(REQ_SCHED,  pack_req($urandom, 3'd0, 16'h0));       // picks thread 1
        send_req(REQ_SLEEP,  pack_req(32'd0, 3'($urandom), 16'($urandom)));  // sleep of zero
        send_req(REQ_SLEEP,  pack_req(32'd3, 3'd7, 16'hFFFF));
        send_req(REQ_SCHED,  pack_req(32'hFFFF_FFFF, 3'd7, 16'hFFFF));
        send_req(REQ_TICK,   pack_req(32'hFFFF_FFFF, 3'd7, 16'h7FFF));
        send_req(REQ_TICK,   pack_req(32'd0, 3'd0, 16'h8000));
        send_req(REQ_SCHED,  pack_req($urandom, 3'($urandom), 16'($urandom)));
        send_req(REQ_TICK,   pack_req($urandom, 3'($urandom), 16'($urandom)));
        // count held at the top: nobody woken
        send_req(REQ_INIT,   pack_req($urandom, 3'd7, 16'h7FFF));
        send_req(REQ_SIGNAL, pack_req($urandom, 3'd7, 16'($urandom)));
        // count held at the bottom: thread still blocks
        send_req(REQ_INIT,   pack_req($urandom, 3'd0, 16'h8000));
        send_req(REQ_WAIT,   pack_req($urandom, 3'd0, 16'($urandom)));
        send_req(REQ_SCHED,  pack_req($urandom, 3'($urandom), 16'($urandom)));
        // init over a blocked thread leaves it blocked
        send_req(REQ_INIT,   pack_req($urandom, 3'd0, 16'd5));
        send_req(REQ_SCHED,  pack_req($urandom, 3'($urandom), 16'($urandom)));
        send_req(REQ_INIT,   pack_req($urandom, 3'd0, 16'hFFFF));
        send_req(REQ_SIGNAL, pack_req($urandom, 3'd0, 16'($urandom)));    // wakes it
        // signal with nobody blocked
        send_req(REQ_SIGNAL, pack_req($urandom, 3'd5, 16'($urandom)));
        send_req(REQ_INIT,   pack_req($urandom, 3'd5, 16'hFFFF));
        send_req(REQ_SIGNAL, pack_req($urandom, 3'd5, 16'($urandom)));    // miss
        send_req(REQ_WAIT,   pack_req($urandom, 3'd2, 16'($urandom)));
        send_req(REQ_SIGNAL, pack_req($urandom, 3'd2, 16'($urandom)));
        // unused request codes
        send_req(3'd6, {5'b0, {51{1'b1}}});
        send_req(3'd7, pack_req(32'd0, 3'd0, 16'h0));
        send_req(REQ_SLEEP,  pack_req(32'hFFFF_FFFF, 3'($urandom), 16'($urandom)));
        send_req(REQ_SCHED,  pack_req($urandom, 3'($urandom), 16'($urandom)));
    endtask

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        bit lvl;
        int n;
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                lvl = 1'b0;
                n   = HOLD_LEN;
            end else if (!m_tready) begin
                lvl = 1'b1;
                n   = $urandom_range(1, 8);
            end else begin
                n = pick_gap();
                lvl = (n == 0);
                if (n == 0) n = $urandom_range(1, 8);
            end
            m_tready <= lvl;
            repeat (n) @(posedge i_clk);
        end
    end

    // Results checked before the request of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_tready) sb.check_result(m_axis_tdata);
            if (s_tvalid && s_axis_tready) sb.note_request(s_tuser, s_tdata);
        end
    end

    // Watchdog: too long with no handshake on either side.
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        bit [7:0] p[8];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset priorities: all equal
        directed_requests();
        run_random(150);

        // many ties; receiver stalls long while requests keep coming
        drain();
        foreach (p[i]) p[i] = 8'($urandom_range(0, 3));
        load_prios(p);
        hold_off = 1'b1;
        run_random(250);

        // extremes, no gaps
        drain();
        foreach (p[i]) p[i] = (i % 2 != 0) ? 8'd254 : 8'd0;
        p[7] = 8'd255;
        load_prios(p);
        calm = 1'b1;
        run_random(150);
        calm = 1'b0;

        // nobody ever eligible
        drain();
        foreach (p[i]) p[i] = 8'd255;
        load_prios(p);
        run_random(40);

        // full range, with a pause until all results are back
        drain();
        foreach (p[i]) p[i] = 8'($urandom_range(0, 255));
        load_prios(p);
        run_random(120);
        drain();
        run_random(130);

        // distinct priorities
        drain();
        foreach (p[i]) p[i] = 8'(7 - i);
        load_prios(p);
        run_random(250);

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
